@@ rtl/core/pasa_pkg.sv @@
// Shared codes and types for the page span allocator.
package pasa_pkg;

   localparam logic [1:0] OP_ALLOC  = 2'd0;
   localparam logic [1:0] OP_FREE   = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NOMEM = 2'd1;
   localparam logic [1:0] ST_BAD   = 2'd2;

   typedef struct packed {
      logic rd;       // read the owner of rd_page
      logic map_go;   // start a sweep writing map_owner over a page range
      logic grow;     // one more fresh chunk is now mapped
   } omap_cmd_type;

endpackage

@@ rtl/core/page_span_allocator_core.sv @@
// Page span allocator: size-list sequencer over span and owner memories.
// Lookup reads the owner map, then the span word. Alloc scans the size lists upward and,
// if none from the request size up holds a span, maps a fresh chunk with an owner sweep
// and scans again; a split adds a sweep over the remainder. Free adds one owner sweep per merged neighbor.
// One request at a time; the next is taken while the previous response waits.
// Reset empties the lists and maps no pages (a fill mark, no clearing pass).
module page_span_allocator_core #(
   parameter int POOL_PAGES     = 4096,
   parameter int MAX_SPAN_PAGES = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [$clog2(MAX_SPAN_PAGES+1)-1:0] req_page_count,
   input  logic [$clog2(POOL_PAGES)-1:0]       req_page_number,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [$clog2(POOL_PAGES)-1:0]       rsp_start_page,
   output logic [$clog2(MAX_SPAN_PAGES+1)-1:0] rsp_span_pages
);
   import pasa_pkg::*;

   localparam int PW   = $clog2(POOL_PAGES);
   localparam int PTRW = PW + 1;
   localparam int LW   = $clog2(MAX_SPAN_PAGES + 1);
   localparam int CW   = $clog2(MAX_SPAN_PAGES + 2);
   localparam int BIW  = $clog2(MAX_SPAN_PAGES);
   localparam int SAW  = $clog2(POOL_PAGES + MAX_SPAN_PAGES);
   localparam logic [PTRW-1:0] NIL = PTRW'(POOL_PAGES);

   localparam logic [4:0] S_IDLE   = 5'd0,  S_FIN    = 5'd1,  S_SCAN   = 5'd2,
                          S_AHEAD  = 5'd3,  S_ASPLIT = 5'd4,  S_APUSHR = 5'd5,
                          S_AMAP   = 5'd6,  S_CHMAP  = 5'd7,  S_CHPUSH = 5'd8,
                          S_FCHK   = 5'd9,  S_FB0    = 5'd10, S_FB1    = 5'd11,
                          S_FB2    = 5'd12, S_FB3    = 5'd13, S_FA0    = 5'd14,
                          S_FA1    = 5'd15, S_FA2    = 5'd16, S_FA3    = 5'd17,
                          S_FPUSH  = 5'd18, S_FDONE  = 5'd19, S_LK1    = 5'd20,
                          S_LK2    = 5'd21, S_U0     = 5'd22, S_U1     = 5'd23,
                          S_U2     = 5'd24, S_U3     = 5'd25, S_U4     = 5'd26,
                          S_P0     = 5'd27, S_P1     = 5'd28, S_P3     = 5'd29,
                          S_P4     = 5'd30, S_MWAIT  = 5'd31;

   typedef struct packed {
      logic [LW-1:0]   len;
      logic            busy;
      logic [PTRW-1:0] nxt;
      logic [PTRW-1:0] prv;
   } span_word_type;

   function automatic logic [SAW-1:0] head_addr(input logic [LW-1:0] len);
      return SAW'(POOL_PAGES) + SAW'(len) - SAW'(1);
   endfunction

   function automatic logic [BIW-1:0] bidx(input logic [LW-1:0] len);
      return BIW'(len - LW'(1));
   endfunction

   // span memory: per-span words at page addresses, list heads above the pool
   span_word_type span_mem [POOL_PAGES + MAX_SPAN_PAGES];
   span_word_type sm_q_ff, sm_wdata;
   logic          sm_re, sm_we;
   logic [SAW-1:0] sm_raddr, sm_waddr;

   always_ff @(posedge clock) begin
      if (sm_re) begin
         sm_q_ff <= span_mem[sm_raddr];
      end
      if (sm_we) begin
         span_mem[sm_waddr] <= sm_wdata;
      end
   end

   omap_cmd_type  om_cmd;
   logic [PW-1:0] om_rd_page, om_q;
   logic          map_busy;
   logic [PW:0]   fill;

   logic [4:0]    state_ff, state_in, ret_ff, ret_in;
   logic [MAX_SPAN_PAGES-1:0] nonempty_ff, nonempty_in;
   logic [LW-1:0] n_ff, n_in, lcur_ff, lcur_in, u_len_ff, u_len_in, m_cnt_ff, m_cnt_in;
   logic [CW-1:0] i_ff, i_in;
   logic          pass_ff, pass_in;
   logic [PW-1:0] p_ff, p_in, s_ff, s_in, cur_ff, cur_in, q_ff, q_in, u_s_ff, u_s_in;
   logic [PW-1:0] m_first_ff, m_first_in, m_owner_ff, m_owner_in;
   logic [PTRW-1:0] u_n_ff, u_n_in, u_p_ff, u_p_in, h_ff, h_in;
   logic [1:0]    res_status_ff, res_status_in;
   logic [PW-1:0] res_start_ff, res_start_in;
   logic [LW-1:0] res_len_ff, res_len_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [PW-1:0] rsp_start_ff, rsp_start_in;
   logic [LW-1:0] rsp_pages_ff, rsp_pages_in;
   logic [PW:0]   nx;
   logic [LW:0]   merged;
   logic          req_mapped;

   pasa_owner_map #(
      .POOL_PAGES    (POOL_PAGES),
      .MAX_SPAN_PAGES(MAX_SPAN_PAGES)
   ) u_owner (
      .clock    (clock),
      .reset    (reset),
      .cmd      (om_cmd),
      .rd_page  (om_rd_page),
      .map_first(m_first_ff),
      .map_count(m_cnt_ff),
      .map_owner(m_owner_ff),
      .rd_owner (om_q),
      .map_busy (map_busy),
      .fill     (fill)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign req_mapped = (32'(req_page_number) < 32'(fill));
   assign nx         = {1'b0, cur_ff} + (PW+1)'(lcur_ff);
   assign merged     = (LW+1)'(sm_q_ff.len) + (LW+1)'(lcur_ff);

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      nonempty_in   = nonempty_ff;
      n_in          = n_ff;
      i_in          = i_ff;
      pass_in       = pass_ff;
      p_in          = p_ff;
      s_in          = s_ff;
      cur_in        = cur_ff;
      lcur_in       = lcur_ff;
      q_in          = q_ff;
      u_s_in        = u_s_ff;
      u_len_in      = u_len_ff;
      u_n_in        = u_n_ff;
      u_p_in        = u_p_ff;
      h_in          = h_ff;
      m_first_in    = m_first_ff;
      m_cnt_in      = m_cnt_ff;
      m_owner_in    = m_owner_ff;
      res_status_in = res_status_ff;
      res_start_in  = res_start_ff;
      res_len_in    = res_len_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_pages_in  = rsp_pages_ff;
      sm_re         = 1'b0;
      sm_raddr      = '0;
      sm_we         = 1'b0;
      sm_waddr      = '0;
      sm_wdata      = '0;
      om_cmd        = '0;
      om_rd_page    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_status_in = ST_BAD;
               res_start_in  = '0;
               res_len_in    = '0;
               state_in      = S_FIN;
               case (req_op)
                  OP_ALLOC: begin
                     if (req_page_count == '0 ||
                         32'(req_page_count) > MAX_SPAN_PAGES) begin
                        res_status_in = ST_NOMEM;
                     end else begin
                        n_in     = LW'(req_page_count);
                        i_in     = CW'(req_page_count);
                        pass_in  = 1'b0;
                        state_in = S_SCAN;
                     end
                  end
                  OP_FREE: begin
                     if (req_mapped) begin
                        p_in       = PW'(req_page_number);
                        om_cmd.rd  = 1'b1;
                        om_rd_page = PW'(req_page_number);
                        sm_re      = 1'b1;
                        sm_raddr   = SAW'(req_page_number);
                        state_in   = S_FCHK;
                     end
                  end
                  OP_LOOKUP: begin
                     if (req_mapped) begin
                        om_cmd.rd  = 1'b1;
                        om_rd_page = PW'(req_page_number);
                        state_in   = S_LK1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_start_in  = res_start_ff;
               rsp_pages_in  = res_len_ff;
               state_in      = S_IDLE;
            end
         end
         // allocation: walk the size lists upward from the request size
         S_SCAN: begin
            if (i_ff > CW'(MAX_SPAN_PAGES)) begin
               if (pass_ff || 32'(fill) + MAX_SPAN_PAGES > POOL_PAGES) begin
                  res_status_in = ST_NOMEM;
                  res_start_in  = '0;
                  res_len_in    = '0;
                  state_in      = S_FIN;
               end else begin
                  m_first_in  = PW'(fill);
                  m_owner_in  = PW'(fill);
                  m_cnt_in    = LW'(MAX_SPAN_PAGES);
                  s_in        = PW'(fill);
                  om_cmd.grow = 1'b1;
                  state_in    = S_CHMAP;
               end
            end else if (nonempty_ff[bidx(LW'(i_ff))]) begin
               sm_re    = 1'b1;
               sm_raddr = head_addr(LW'(i_ff));
               state_in = S_AHEAD;
            end else begin
               i_in = i_ff + CW'(1);
            end
         end
         S_CHMAP: begin
            om_cmd.map_go = 1'b1;
            ret_in        = S_CHPUSH;
            state_in      = S_MWAIT;
         end
         S_CHPUSH: begin
            u_s_in   = s_ff;
            u_len_in = LW'(MAX_SPAN_PAGES);
            i_in     = CW'(n_ff);
            pass_in  = 1'b1;
            ret_in   = S_SCAN;
            state_in = S_P0;
         end
         S_AHEAD: begin
            s_in       = sm_q_ff.nxt[PW-1:0];
            u_s_in     = sm_q_ff.nxt[PW-1:0];
            u_len_in   = LW'(i_ff);
            q_in       = sm_q_ff.nxt[PW-1:0] + PW'(n_ff);
            m_first_in = sm_q_ff.nxt[PW-1:0] + PW'(n_ff);
            m_owner_in = sm_q_ff.nxt[PW-1:0] + PW'(n_ff);
            m_cnt_in   = LW'(i_ff) - n_ff;
            ret_in     = S_ASPLIT;
            state_in   = S_U0;
         end
         S_ASPLIT: begin
            if (LW'(i_ff) > n_ff) begin
               om_cmd.map_go = 1'b1;
               ret_in        = S_APUSHR;
               state_in      = S_MWAIT;
            end else begin
               state_in = S_AMAP;
            end
         end
         S_APUSHR: begin
            u_s_in   = q_ff;
            u_len_in = LW'(i_ff) - n_ff;
            ret_in   = S_AMAP;
            state_in = S_P0;
         end
         S_AMAP: begin
            sm_we         = 1'b1;
            sm_waddr      = SAW'(s_ff);
            sm_wdata      = '{len: n_ff, busy: 1'b1, nxt: NIL, prv: NIL};
            res_status_in = ST_OK;
            res_start_in  = s_ff;
            res_len_in    = n_ff;
            state_in      = S_FIN;
         end
         // free: validate, merge backward, then forward
         S_FCHK: begin
            if (om_q != p_ff || !sm_q_ff.busy) begin
               state_in = S_FIN;
            end else begin
               cur_in   = p_ff;
               lcur_in  = sm_q_ff.len;
               state_in = S_FB0;
            end
         end
         S_FB0: begin
            if (cur_ff == '0) begin
               state_in = S_FA0;
            end else begin
               om_cmd.rd  = 1'b1;
               om_rd_page = cur_ff - PW'(1);
               state_in   = S_FB1;
            end
         end
         S_FB1: begin
            q_in     = om_q;
            sm_re    = 1'b1;
            sm_raddr = SAW'(om_q);
            state_in = S_FB2;
         end
         S_FB2: begin
            if (sm_q_ff.busy || merged > (LW+1)'(MAX_SPAN_PAGES)) begin
               state_in = S_FA0;
            end else begin
               m_first_in = cur_ff;
               m_cnt_in   = lcur_ff;
               m_owner_in = q_ff;
               lcur_in    = LW'(merged);
               cur_in     = q_ff;
               u_s_in     = q_ff;
               u_len_in   = sm_q_ff.len;
               ret_in     = S_FB3;
               state_in   = S_U0;
            end
         end
         S_FB3: begin
            om_cmd.map_go = 1'b1;
            ret_in        = S_FB0;
            state_in      = S_MWAIT;
         end
         S_FA0: begin
            // the fill mark bounds both the pool edge and the mapped range
            if (nx >= fill) begin
               state_in = S_FPUSH;
            end else begin
               om_cmd.rd  = 1'b1;
               om_rd_page = PW'(nx);
               state_in   = S_FA1;
            end
         end
         S_FA1: begin
            q_in     = om_q;
            sm_re    = 1'b1;
            sm_raddr = SAW'(om_q);
            state_in = S_FA2;
         end
         S_FA2: begin
            if (sm_q_ff.busy || merged > (LW+1)'(MAX_SPAN_PAGES)) begin
               state_in = S_FPUSH;
            end else begin
               m_first_in = q_ff;
               m_cnt_in   = sm_q_ff.len;
               m_owner_in = cur_ff;
               lcur_in    = LW'(merged);
               u_s_in     = q_ff;
               u_len_in   = sm_q_ff.len;
               ret_in     = S_FA3;
               state_in   = S_U0;
            end
         end
         S_FA3: begin
            om_cmd.map_go = 1'b1;
            ret_in        = S_FA0;
            state_in      = S_MWAIT;
         end
         S_FPUSH: begin
            u_s_in   = cur_ff;
            u_len_in = lcur_ff;
            ret_in   = S_FDONE;
            state_in = S_P0;
         end
         S_FDONE: begin
            res_status_in = ST_OK;
            res_start_in  = cur_ff;
            res_len_in    = lcur_ff;
            state_in      = S_FIN;
         end
         S_LK1: begin
            q_in     = om_q;
            sm_re    = 1'b1;
            sm_raddr = SAW'(om_q);
            state_in = S_LK2;
         end
         S_LK2: begin
            res_status_in = ST_OK;
            res_start_in  = q_ff;
            res_len_in    = sm_q_ff.len;
            state_in      = S_FIN;
         end
         // unlink u_s from list u_len
         S_U0: begin
            sm_re    = 1'b1;
            sm_raddr = SAW'(u_s_ff);
            state_in = S_U1;
         end
         S_U1: begin
            u_n_in = sm_q_ff.nxt;
            u_p_in = sm_q_ff.prv;
            if (sm_q_ff.prv != NIL) begin
               sm_re    = 1'b1;
               sm_raddr = SAW'(sm_q_ff.prv);
               state_in = S_U2;
            end else begin
               sm_we    = 1'b1;
               sm_waddr = head_addr(u_len_ff);
               sm_wdata = '{len: '0, busy: 1'b0, nxt: sm_q_ff.nxt, prv: NIL};
               nonempty_in[bidx(u_len_ff)] = (sm_q_ff.nxt != NIL);
               state_in = S_U3;
            end
         end
         S_U2: begin
            sm_we        = 1'b1;
            sm_waddr     = SAW'(u_p_ff);
            sm_wdata     = sm_q_ff;
            sm_wdata.nxt = u_n_ff;
            state_in     = S_U3;
         end
         S_U3: begin
            if (u_n_ff != NIL) begin
               sm_re    = 1'b1;
               sm_raddr = SAW'(u_n_ff);
               state_in = S_U4;
            end else begin
               state_in = ret_ff;
            end
         end
         S_U4: begin
            sm_we        = 1'b1;
            sm_waddr     = SAW'(u_n_ff);
            sm_wdata     = sm_q_ff;
            sm_wdata.prv = u_p_ff;
            state_in     = ret_ff;
         end
         // push u_s as a free span of u_len pages
         S_P0: begin
            if (nonempty_ff[bidx(u_len_ff)]) begin
               sm_re    = 1'b1;
               sm_raddr = head_addr(u_len_ff);
               state_in = S_P1;
            end else begin
               sm_we    = 1'b1;
               sm_waddr = SAW'(u_s_ff);
               sm_wdata = '{len: u_len_ff, busy: 1'b0, nxt: NIL, prv: NIL};
               state_in = S_P4;
            end
         end
         S_P1: begin
            h_in     = sm_q_ff.nxt;
            sm_we    = 1'b1;
            sm_waddr = SAW'(u_s_ff);
            sm_wdata = '{len: u_len_ff, busy: 1'b0, nxt: sm_q_ff.nxt, prv: NIL};
            sm_re    = 1'b1;
            sm_raddr = SAW'(sm_q_ff.nxt);
            state_in = S_P3;
         end
         S_P3: begin
            sm_we        = 1'b1;
            sm_waddr     = SAW'(h_ff);
            sm_wdata     = sm_q_ff;
            sm_wdata.prv = {1'b0, u_s_ff};
            state_in     = S_P4;
         end
         S_P4: begin
            sm_we    = 1'b1;
            sm_waddr = head_addr(u_len_ff);
            sm_wdata = '{len: '0, busy: 1'b0, nxt: {1'b0, u_s_ff}, prv: NIL};
            nonempty_in[bidx(u_len_ff)] = 1'b1;
            state_in = ret_ff;
         end
         S_MWAIT: begin
            if (!map_busy) begin
               state_in = ret_ff;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      ret_ff        <= ret_in;
      n_ff          <= n_in;
      i_ff          <= i_in;
      pass_ff       <= pass_in;
      p_ff          <= p_in;
      s_ff          <= s_in;
      cur_ff        <= cur_in;
      lcur_ff       <= lcur_in;
      q_ff          <= q_in;
      u_s_ff        <= u_s_in;
      u_len_ff      <= u_len_in;
      u_n_ff        <= u_n_in;
      u_p_ff        <= u_p_in;
      h_ff          <= h_in;
      m_first_ff    <= m_first_in;
      m_cnt_ff      <= m_cnt_in;
      m_owner_ff    <= m_owner_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      res_len_ff    <= res_len_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_pages_ff  <= rsp_pages_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         nonempty_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nonempty_ff  <= nonempty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_start_page = rsp_start_ff;
   assign rsp_span_pages = rsp_pages_ff;

`ifndef SYNTHESIS
   a_err_zero_fields: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FIN && res_status_ff != ST_OK |-> res_start_ff == '0 && res_len_ff == '0)
      else $error("error response carries span data");
   a_ok_len_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FIN && res_status_ff == ST_OK |->
         res_len_ff != '0 && res_len_ff <= LW'(MAX_SPAN_PAGES))
      else $error("span length out of range");
   a_head_not_nil: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_P1 |-> sm_q_ff.nxt != NIL)
      else $error("nonempty list has nil head");
`endif

endmodule

@@ rtl/core/pasa_owner_map.sv @@
// Page owner memory with range-write sweep and mapped-pool fill mark.
module pasa_owner_map #(
   parameter int POOL_PAGES     = 4096,
   parameter int MAX_SPAN_PAGES = 128
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pasa_pkg::omap_cmd_type            cmd,
   input  logic [$clog2(POOL_PAGES)-1:0]     rd_page,
   input  logic [$clog2(POOL_PAGES)-1:0]     map_first,
   input  logic [$clog2(MAX_SPAN_PAGES+1)-1:0] map_count,
   input  logic [$clog2(POOL_PAGES)-1:0]     map_owner,
   output logic [$clog2(POOL_PAGES)-1:0]     rd_owner,
   output logic                              map_busy,
   output logic [$clog2(POOL_PAGES):0]       fill
);
   import pasa_pkg::*;

   localparam int PW = $clog2(POOL_PAGES);
   localparam int LW = $clog2(MAX_SPAN_PAGES + 1);

   logic [PW-1:0] owner_mem [POOL_PAGES];
   logic [PW-1:0] rd_owner_ff;
   logic [PW-1:0] sw_page_ff, sw_page_in;
   logic [PW-1:0] sw_owner_ff, sw_owner_in;
   logic [LW-1:0] sw_cnt_ff, sw_cnt_in;
   logic [PW:0]   fill_ff, fill_in;

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rd_owner_ff <= owner_mem[rd_page];
      end
      if (sw_cnt_ff != '0) begin
         owner_mem[sw_page_ff] <= sw_owner_ff;
      end
   end

   always_comb begin
      sw_page_in  = sw_page_ff;
      sw_owner_in = sw_owner_ff;
      sw_cnt_in   = sw_cnt_ff;
      if (cmd.map_go) begin
         sw_page_in  = map_first;
         sw_owner_in = map_owner;
         sw_cnt_in   = map_count;
      end else if (sw_cnt_ff != '0) begin
         sw_page_in = sw_page_ff + PW'(1);
         sw_cnt_in  = sw_cnt_ff - LW'(1);
      end
      fill_in = cmd.grow ? fill_ff + (PW+1)'(MAX_SPAN_PAGES) : fill_ff;
   end

   always_ff @(posedge clock) begin
      sw_page_ff  <= sw_page_in;
      sw_owner_ff <= sw_owner_in;
      if (reset) begin
         sw_cnt_ff <= '0;
         fill_ff   <= '0;
      end else begin
         sw_cnt_ff <= sw_cnt_in;
         fill_ff   <= fill_in;
      end
   end

   assign rd_owner = rd_owner_ff;
   assign map_busy = (sw_cnt_ff != '0);
   assign fill     = fill_ff;

`ifndef SYNTHESIS
   a_no_go_while_busy: assert property (@(posedge clock) disable iff (reset)
      !(cmd.map_go && map_busy)) else $error("sweep restarted while running");
   a_no_read_while_busy: assert property (@(posedge clock) disable iff (reset)
      !(cmd.rd && map_busy)) else $error("owner read during sweep");
   a_fill_in_pool: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= (PW+1)'(POOL_PAGES)) else $error("fill mark beyond pool");
`endif

endmodule

@@ tb/sv/tb_page_span_allocator_core.sv @@
// Self-checking testbench for the page span allocator: random and directed requests.
module tb_page_span_allocator_core;
   timeunit 1ns;
   timeprecision 1ps;
   import pasa_pkg::*;

   localparam int POOL      = 4096;
   localparam int MAX_SPAN  = 128;
   localparam int NIL       = POOL;
   localparam int SETTLE    = 600;
   localparam int LIMIT     = 4000000;
   localparam int PHASE_ITEMS = 210;
   localparam logic [1:0] OP_UNKNOWN = 2'd3;

   typedef struct {
      logic [1:0]  op;
      logic [7:0]  count;
      logic [11:0] page;
   } span_req_t;

   typedef struct {
      logic [1:0]  status;
      logic [11:0] start;
      logic [7:0]  pages;
   } span_rsp_t;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_op = OP_LOOKUP;
   logic [7:0]  req_page_count = 0;
   logic [11:0] req_page_number = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [1:0]  rsp_status;
   logic [11:0] rsp_start_page;
   logic [7:0]  rsp_span_pages;

   page_span_allocator_core u_dut (.*);

   always #4 clock = ~clock;

   // shadow of the allocator state
   int owner [POOL];
   int slen  [POOL];
   bit sbusy [POOL];
   int fnext [POOL];
   int fprev [POOL];
   int lhead [MAX_SPAN];
   int chunks;

   span_req_t pending_reqs[$];
   span_rsp_t expected_rsps[$];
   int        live_spans[$];
   int        mismatches = 0;
   int        cycles = 0;
   int        idle_pct = 0;
   int        stall_pct = 0;
   int        phase_no = 0;
   bit        long_hold = 0;
   bit        taken = 0;

   function automatic span_rsp_t mk(logic [1:0] st, int s, int n);
      span_rsp_t r;
      r.status = st;
      r.start  = (st == ST_OK) ? s[11:0] : '0;
      r.pages  = (st == ST_OK) ? n[7:0] : '0;
      return r;
   endfunction

   function automatic void list_push(int s);
      int h;
      h = lhead[slen[s]-1];
      fnext[s] = h;
      fprev[s] = NIL;
      if (h < NIL) fprev[h] = s;
      lhead[slen[s]-1] = s;
   endfunction

   function automatic void list_unlink(int s);
      int n, p;
      n = fnext[s];
      p = fprev[s];
      if (p < NIL) fnext[p] = n;
      else lhead[slen[s]-1] = n;
      if (n < NIL) fprev[n] = p;
   endfunction

   function automatic void map_pages(int first, int cnt, int own);
      for (int i = first; i < first + cnt; i++)
         if (i < POOL) owner[i] = own;
   endfunction

   function automatic span_rsp_t alloc_span(int n);
      int s, r, c;
      if (n < 1 || n > MAX_SPAN) return mk(ST_NOMEM, 0, 0);
      for (int pass = 0; pass < 2; pass++) begin
         for (int i = n; i <= MAX_SPAN; i++) begin
            s = lhead[i-1];
            if (s >= NIL) continue;
            list_unlink(s);
            if (i > n) begin
               r = s + n;
               slen[r] = i - n;
               sbusy[r] = 0;
               map_pages(r, i - n, r);
               list_push(r);
            end
            slen[s] = n;
            sbusy[s] = 1;
            map_pages(s, n, s);
            return mk(ST_OK, s, n);
         end
         if ((chunks + 1) * MAX_SPAN > POOL) return mk(ST_NOMEM, 0, 0);
         c = chunks * MAX_SPAN;
         chunks++;
         slen[c] = MAX_SPAN;
         sbusy[c] = 0;
         map_pages(c, MAX_SPAN, c);
         list_push(c);
      end
      return mk(ST_NOMEM, 0, 0);
   endfunction

   function automatic span_rsp_t free_span(int p);
      int cur, q, nx, r;
      if (owner[p] != p || !sbusy[p]) return mk(ST_BAD, 0, 0);
      cur = p;
      sbusy[cur] = 0;
      while (cur > 0) begin
         q = owner[cur-1];
         if (q >= NIL || sbusy[q]) break;
         if (slen[q] + slen[cur] > MAX_SPAN) break;
         list_unlink(q);
         map_pages(cur, slen[cur], q);
         slen[q] = slen[q] + slen[cur];
         cur = q;
      end
      forever begin
         nx = cur + slen[cur];
         if (nx >= POOL) break;
         r = owner[nx];
         if (r >= NIL || sbusy[r]) break;
         if (slen[cur] + slen[r] > MAX_SPAN) break;
         list_unlink(r);
         map_pages(r, slen[r], cur);
         slen[cur] = slen[cur] + slen[r];
      end
      list_push(cur);
      return mk(ST_OK, cur, slen[cur]);
   endfunction

   function automatic span_rsp_t predict_span(span_req_t q);
      span_rsp_t r;
      case (q.op)
         OP_ALLOC: begin
            r = alloc_span(q.count);
            if (r.status == ST_OK) live_spans.push_back(r.start);
         end
         OP_FREE: r = free_span(q.page);
         OP_LOOKUP: begin
            if (owner[q.page] >= NIL) r = mk(ST_BAD, 0, 0);
            else r = mk(ST_OK, owner[q.page], slen[owner[q.page]]);
         end
         default: r = mk(ST_BAD, 0, 0);
      endcase
      return r;
   endfunction

   // acceptance and response checking at the rising edge
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("%0t timeout", $realtime);
         $display("status: fail");
         $finish;
      end
      if (!reset && req_valid && !req_stall) begin
         expected_rsps.push_back(predict_span('{req_op, req_page_count, req_page_number}));
         taken = 1;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t unexpected response status=%0d start=%0d pages=%0d", $realtime,
                     rsp_status, rsp_start_page, rsp_span_pages);
            mismatches++;
         end else begin
            span_rsp_t e;
            e = expected_rsps.pop_front();
            if (e.status !== rsp_status) begin
               $display("%0t status exp %0d got %0d", $realtime, e.status, rsp_status);
               mismatches++;
            end
            if (e.start !== rsp_start_page) begin
               $display("%0t start_page exp %0d got %0d", $realtime, e.start, rsp_start_page);
               mismatches++;
            end
            if (e.pages !== rsp_span_pages) begin
               $display("%0t span_pages exp %0d got %0d", $realtime, e.pages, rsp_span_pages);
               mismatches++;
            end
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      if (!reset && (taken || !req_valid)) begin
         taken = 0;
         if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
            span_req_t q;
            q = pending_reqs.pop_front();
            req_op          <= q.op;
            req_page_count  <= q.count;
            req_page_number <= q.page;
            req_valid       <= 1;
         end else begin
            req_valid <= 0;
         end
      end
      rsp_stall <= long_hold || ($urandom_range(99) < stall_pct);
   end

   // long receiver hold so the block backs up into its input
   initial begin
      wait (phase_no == 1);
      repeat (40) @(posedge clock);
      long_hold = 1;
      repeat (400) @(posedge clock);
      long_hold = 0;
   end

   task automatic send(logic [1:0] op, int cnt, int pg);
      while (pending_reqs.size() > 2) @(posedge clock);
      pending_reqs.push_back('{op, cnt[7:0], pg[11:0]});
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic random_req();
      int k, pct, idx, cnt;
      pct = $urandom_range(99);
      if (pct < 45) begin
         k = $urandom_range(99);
         if (k < 70) cnt = $urandom_range(1, 16);
         else if (k < 90) cnt = $urandom_range(1, MAX_SPAN);
         else if (k < 97) cnt = MAX_SPAN;
         else cnt = $urandom_range(0, 255);
         send(OP_ALLOC, cnt, $urandom_range(0, 4095));
      end else if (pct < 80 && live_spans.size() > 0) begin
         idx = $urandom_range(live_spans.size() - 1);
         send(OP_FREE, $urandom_range(0, 255), live_spans[idx]);
         live_spans.delete(idx);
      end else if (pct < 95) begin
         send(OP_LOOKUP, $urandom_range(0, 255), $urandom_range(0, 4095));
      end else if (pct < 98) begin
         send(OP_FREE, $urandom_range(0, 255), $urandom_range(0, 4095));
      end else begin
         send(OP_UNKNOWN, $urandom_range(0, 255), $urandom_range(0, 4095));
      end
   endtask

   initial begin
      for (int i = 0; i < POOL; i++) owner[i] = NIL;
      for (int i = 0; i < MAX_SPAN; i++) lhead[i] = NIL;
      chunks = 0;
      repeat (6) @(posedge clock);
      reset <= 0;

      send(OP_LOOKUP, 0, 0);
      send(OP_LOOKUP, 255, 4095);
      send(OP_UNKNOWN, 255, 4095);
      send(OP_FREE, 0, 0);          // unmapped
      send(OP_ALLOC, 0, 0);
      send(OP_ALLOC, 129, 0);
      send(OP_ALLOC, 255, 0);
      send(OP_ALLOC, 1, 0);
      send(OP_ALLOC, MAX_SPAN, 0);
      send(OP_ALLOC, 127, 0);       // takes the first chunk's remainder whole
      send(OP_ALLOC, 3, 0);
      send(OP_LOOKUP, 0, 200);
      send(OP_LOOKUP, 0, 300);      // lookup inside a free span
      send(OP_FREE, 0, 5);          // not a span start
      send(OP_FREE, 0, 1);
      send(OP_FREE, 0, 1);          // double free
      send(OP_FREE, 0, 0);          // merge forward
      send(OP_FREE, 0, 128);        // merge blocked by length
      send(OP_FREE, 0, 256);
      send(OP_LOOKUP, 0, 300);
      drain();
      live_spans.delete();

      for (int ph = 0; ph < 4; ph++) begin
         phase_no = ph;
         idle_pct  = (ph == 1) ? 50 : (ph == 3) ? 23 : 0;
         stall_pct = (ph == 2) ? 50 : (ph == 3) ? 23 : 0;
         for (int i = 0; i < PHASE_ITEMS; i++) random_req();
         drain();
      end

      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

@@ page_span_allocator_core.f @@
rtl/core/pasa_pkg.sv
rtl/core/pasa_owner_map.sv
rtl/core/page_span_allocator_core.sv
tb/sv/tb_page_span_allocator_core.sv
